@@ design/ctd_pkg.sv @@
`timescale 1ns / 1ps

package ctd_pkg;

    // field and state widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 27;
    localparam int COUNT_W  = 11;
    localparam int CAL_W    = 10;
    localparam int HIST_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // running count is halved once it passes this
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd1000;

    // full-scale sample value
    localparam logic [SAMPLE_W-1:0] FULL16 = 16'hFFFF;

    // register reset values
    localparam logic [CAL_W-1:0]    CAL_RESET    = 10'd100;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'd50;
    localparam logic [HIST_W-1:0]   MASK_RESET   = 32'd15;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CAL    = 2'd0,
        REG_THRESH = 2'd1,
        REG_MASK   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

endpackage

@@ design/ctd_divider.sv @@
`timescale 1ns / 1ps

module ctd_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ctd_pkg::SUM_W-1:0]     dividend,
    input  logic [ctd_pkg::COUNT_W-1:0]   divisor,
    output logic                          done,
    output logic [ctd_pkg::SAMPLE_W-1:0]  quotient
);
    import ctd_pkg::*;

    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_W - 1);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t            state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    divisor_reg;
    logic [SAMPLE_W-1:0]   quot_reg;
    logic                  sat_reg;
    logic                  done_reg;

    logic [COUNT_W:0]      rem_shift;
    logic [COUNT_W:0]      diff;
    logic                  fits;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[SAMPLE_W-1]};
        diff      = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
    end

    // sequencer: upper bits checked for overflow at load, then one bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DIV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DIV_RUN;
                        step_reg  <= '0;
                    end
                end
                DIV_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= DIV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    // datapath: quot_reg holds the low dividend bits and shifts the quotient in behind them
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= dividend[SUM_W-1:SAMPLE_W];
            quot_reg    <= dividend[SAMPLE_W-1:0];
            sat_reg     <= ({1'b0, dividend[SUM_W-1:SAMPLE_W]} >= {1'b0, divisor});
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg  <= fits ? diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quot_reg <= {quot_reg[SAMPLE_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? FULL16 : quot_reg;

endmodule

@@ design/cap_touch_detector.sv @@
`timescale 1ns / 1ps
// from sample acceptance to result valid: ST_START starts the bit-serial divider
//   that forms the baseline (16 quotient steps), ST_DIVIDE waits for its done and
//   ST_FINISH writes the result once the result side keeps up
// a new sample is taken only in ST_IDLE, after the current one is written out
// reset: tracking state, flags, configuration registers and result valid return to
//   their reset values; the block is ready as soon as reset is released

module cap_touch_detector
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ctd_pkg::DATA_W-1:0]    pwdata,
    output logic [ctd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [ctd_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          clear_touch,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          pressed,
    output logic                          touch_latched,
    output logic                          above_threshold,
    output logic [ctd_pkg::SAMPLE_W-1:0]  baseline,
    output logic [ctd_pkg::SAMPLE_W-1:0]  peak_high,
    output logic [ctd_pkg::SAMPLE_W-1:0]  peak_low
);
    import ctd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [CAL_W-1:0]    cal_reg;
    logic [SAMPLE_W-1:0] thresh_reg;
    logic [HIST_W-1:0]   mask_reg;

    // tracking state
    state_t              state_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [HIST_W-1:0]   hist_reg;
    logic                pressed_reg;
    logic                latch_reg;
    logic                above_reg;

    // result register
    logic                out_valid_reg;
    logic                out_pressed_reg;
    logic                out_latch_reg;
    logic                out_above_reg;
    logic [SAMPLE_W-1:0] out_base_reg;
    logic [SAMPLE_W-1:0] out_high_reg;
    logic [SAMPLE_W-1:0] out_low_reg;

    logic                in_fire;
    logic                cfg_write;
    reg_idx_t            cfg_idx;
    logic                slot_free;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;

    logic [SAMPLE_W:0]   limit;
    logic                above_next;
    logic [HIST_W-1:0]   hist_next;
    logic [HIST_W-1:0]   masked;
    logic                pressed_next;

    assign in_fire   = sample_valid && sample_ready;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign slot_free = !out_valid_reg || result_ready;

    // baseline divider
    ctd_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // threshold test against the previous baseline, at 17 bits
    always_comb
    begin
        limit      = {1'b0, avg_reg} + {1'b0, thresh_reg};
        above_next = ({1'b0, count_reg} >= {2'b00, cal_reg}) &&
                     ({1'b0, sample} > limit);
    end

    // debounce of the history
    always_comb
    begin
        hist_next    = {hist_reg[HIST_W-2:0], above_reg};
        masked       = hist_next & mask_reg;
        pressed_next = pressed_reg;
        if (pressed_next && masked == '0)
        begin
            pressed_next = 1'b0;
        end
        if (!pressed_next && masked == mask_reg)
        begin
            pressed_next = 1'b1;
        end
    end

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg    <= CAL_RESET;
            thresh_reg <= THRESH_RESET;
            mask_reg   <= MASK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_CAL:    cal_reg    <= pwdata[CAL_W-1:0];
                REG_THRESH: thresh_reg <= pwdata[SAMPLE_W-1:0];
                REG_MASK:   mask_reg   <= pwdata[HIST_W-1:0];
                default:    ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_CAL:    prdata = {{(DATA_W-CAL_W){1'b0}}, cal_reg};
            REG_THRESH: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thresh_reg};
            REG_MASK:   prdata = mask_reg;
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // item sequencer and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= FULL16;
            max_reg       <= '0;
            min_reg       <= FULL16;
            hist_reg      <= '0;
            pressed_reg   <= 1'b0;
            latch_reg     <= 1'b0;
            above_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (clear_touch)
                        begin
                            latch_reg <= 1'b0;
                        end
                        if (sample > max_reg)
                        begin
                            max_reg <= sample;
                        end
                        if (sample < min_reg)
                        begin
                            min_reg <= sample;
                        end
                        above_reg <= above_next;
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        avg_reg     <= div_quot;
                        if (count_reg > COUNT_LIMIT)
                        begin
                            count_reg <= count_reg >> 1;
                            sum_reg   <= sum_reg >> 1;
                        end
                        hist_reg    <= hist_next;
                        pressed_reg <= pressed_next;
                        if (pressed_next)
                        begin
                            latch_reg <= 1'b1;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && slot_free)
        begin
            out_pressed_reg <= pressed_next;
            out_latch_reg   <= latch_reg || pressed_next;
            out_above_reg   <= above_reg;
            out_base_reg    <= div_quot;
            out_high_reg    <= max_reg;
            out_low_reg     <= min_reg;
        end
    end

    assign sample_ready    = (state_reg == ST_IDLE);
    assign result_valid    = out_valid_reg;
    assign pressed         = out_pressed_reg;
    assign touch_latched   = out_latch_reg;
    assign above_threshold = out_above_reg;
    assign baseline        = out_base_reg;
    assign peak_high       = out_high_reg;
    assign peak_low        = out_low_reg;

endmodule
